FILE: hdl/fdr_pkg.sv
`timescale 1ns / 1ps
package fdr_pkg;

  // Fraction bits of the amplitude ratios.
  localparam int FRAC_BITS = 20;
  // One square-root step per stage; the radicand is below 2^62.
  localparam int SQRT_STEPS = 31;
  // 1.0 in Q1.16.
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Word carried through the square-root stages.
  typedef struct packed {
    logic        tir;
    logic [15:0] c;
    logic [15:0] ii;
    logic [31:0] tt2;
    logic [61:0] v;
    logic [62:0] r;
  } sq_t;

  // Word carried through the two long dividers.
  typedef struct packed {
    logic                 tir;
    logic                 one_p;
    logic [48:0]          den_p;
    logic [49:0]          rem_p;
    logic [FRAC_BITS-1:0] q_p;
    logic                 one_s;
    logic [32:0]          den_s;
    logic [33:0]          rem_s;
    logic [FRAC_BITS-1:0] q_s;
  } dv_t;

endpackage

FILE: hdl/fresnel_dielectric_reflectance_top.sv
// Throughput: one word per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, and holds in place otherwise.
// Depth is set by the 31 square-root stages and the 20 divider stages.
// Reset (rst, synchronous, active high) clears all valid bits; data is not reset.
`timescale 1ns / 1ps
module fresnel_dielectric_reflectance_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] cos_incident,
  input  logic [15:0] index_incident,
  input  logic [15:0] index_transmit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] reflectance,
  output logic        total_internal
);

  localparam int FB = fdr_pkg::FRAC_BITS;
  localparam int NS = fdr_pkg::SQRT_STEPS;

  logic ce;
  assign ce       = !out_valid || out_ready;
  assign in_ready = ce;

  // Stage 1: orient the boundary and square the inputs.
  logic        v1;
  logic [15:0] c1, ii1;
  logic [30:0] cc1;
  logic [31:0] ii2_1, tt2_1;
  logic        entering;
  logic [15:0] c_mag, ii_sel, tt_sel;

  always_comb begin
    entering = (cos_incident != 16'd0) && !cos_incident[15];
    c_mag    = entering ? cos_incident : 16'(-cos_incident);
    ii_sel   = entering ? index_incident : index_transmit;
    tt_sel   = entering ? index_transmit : index_incident;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
    end
    if (ce) begin
      c1    <= c_mag;
      ii1   <= ii_sel;
      cc1   <= 31'(c_mag) * 31'(c_mag);
      ii2_1 <= 32'(ii_sel) * 32'(ii_sel);
      tt2_1 <= 32'(tt_sel) * 32'(tt_sel);
    end
  end

  // Stage 2: sine squared and its product with the incident index squared.
  logic        v2;
  logic [15:0] c2, ii2r;
  logic [31:0] tt2_2;
  logic [47:0] plo2;
  logic [46:0] phi2;
  logic [30:0] s_sq;

  assign s_sq = 31'h4000_0000 - cc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
    if (ce) begin
      c2    <= c1;
      ii2r  <= ii1;
      tt2_2 <= tt2_1;
      plo2  <= 48'(ii2_1) * 48'(s_sq[15:0]);
      phi2  <= 47'(ii2_1) * 47'(s_sq[30:16]);
    end
  end

  // Stage 3: join the partial products.
  logic        v3;
  logic [15:0] c3, ii3;
  logic [31:0] tt2_3;
  logic [62:0] iis3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ce) begin
      v3 <= v2;
    end
    if (ce) begin
      c3    <= c2;
      ii3   <= ii2r;
      tt2_3 <= tt2_2;
      iis3  <= 63'(plo2) + {phi2, 16'd0};
    end
  end

  // Stage 4: total internal reflection test and the square-root radicand.
  logic [62:0] tt30;
  logic        tir4;
  fdr_pkg::sq_t sq [0:NS];
  logic         sqv [0:NS];

  assign tt30 = {1'b0, tt2_3, 30'd0};
  assign tir4 = iis3 >= tt30;

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv[0] <= 1'b0;
    end else if (ce) begin
      sqv[0] <= v3;
    end
    if (ce) begin
      sq[0].tir <= tir4;
      sq[0].c   <= c3;
      sq[0].ii  <= ii3;
      sq[0].tt2 <= tt2_3;
      sq[0].v   <= tir4 ? 62'd0 : 62'(tt30 - iis3);
      sq[0].r   <= 63'd0;
    end
  end

  // Square root, one result bit per stage.
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'(1) << (60 - 2 * k);
    fdr_pkg::sq_t nxt;
    logic [62:0]  rb;

    always_comb begin
      nxt = sq[k];
      rb  = sq[k].r + BIT;
      if ({1'b0, sq[k].v} >= rb) begin
        nxt.v = sq[k].v - rb[61:0];
        nxt.r = (sq[k].r >> 1) + BIT;
      end else begin
        nxt.r = sq[k].r >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[k+1] <= 1'b0;
      end else if (ce) begin
        sqv[k+1] <= sqv[k];
      end
      if (ce) begin
        sq[k+1] <= nxt;
      end
    end
  end

  // Products that form the two amplitude ratios.
  logic        vm;
  logic        tirm;
  logic [47:0] ap;
  logic [46:0] bp;
  logic [31:0] as_m;
  logic [30:0] bs;
  logic [30:0] qroot;

  assign qroot = sq[NS].r[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (ce) begin
      vm <= sqv[NS];
    end
    if (ce) begin
      tirm <= sq[NS].tir;
      ap   <= 48'(sq[NS].tt2) * 48'(sq[NS].c);
      bp   <= 47'(sq[NS].ii) * 47'(qroot);
      as_m <= 32'(sq[NS].ii) * 32'(sq[NS].c);
      bs   <= qroot;
    end
  end

  // Numerators and denominators of both ratios.
  fdr_pkg::dv_t dv [0:FB];
  logic         dvv [0:FB];
  logic [48:0]  nump, denp;
  logic [32:0]  nums, dens;

  always_comb begin
    nump = (ap > 48'(bp)) ? 49'(ap - 48'(bp)) : 49'(48'(bp) - ap);
    denp = 49'(ap) + 49'(bp);
    nums = (as_m > 32'(bs)) ? 33'(as_m - 32'(bs)) : 33'(32'(bs) - as_m);
    dens = 33'(as_m) + 33'(bs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (ce) begin
      dvv[0] <= vm;
    end
    if (ce) begin
      dv[0].tir   <= tirm;
      dv[0].one_p <= (denp == 49'd0) || (nump >= denp);
      dv[0].den_p <= denp;
      dv[0].rem_p <= {1'b0, nump};
      dv[0].q_p   <= '0;
      dv[0].one_s <= (dens == 33'd0) || (nums >= dens);
      dv[0].den_s <= dens;
      dv[0].rem_s <= {1'b0, nums};
      dv[0].q_s   <= '0;
    end
  end

  // Both long divisions, one quotient bit per stage.
  for (genvar k = 0; k < FB; k++) begin : g_div
    fdr_pkg::dv_t nxt;
    logic [49:0]  rp2;
    logic [33:0]  rs2;

    always_comb begin
      nxt = dv[k];
      rp2 = {dv[k].rem_p[48:0], 1'b0};
      rs2 = {dv[k].rem_s[32:0], 1'b0};
      if (rp2 >= {1'b0, dv[k].den_p}) begin
        nxt.rem_p = rp2 - {1'b0, dv[k].den_p};
        nxt.q_p   = {dv[k].q_p[FB-2:0], 1'b1};
      end else begin
        nxt.rem_p = rp2;
        nxt.q_p   = {dv[k].q_p[FB-2:0], 1'b0};
      end
      if (rs2 >= {1'b0, dv[k].den_s}) begin
        nxt.rem_s = rs2 - {1'b0, dv[k].den_s};
        nxt.q_s   = {dv[k].q_s[FB-2:0], 1'b1};
      end else begin
        nxt.rem_s = rs2;
        nxt.q_s   = {dv[k].q_s[FB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (ce) begin
        dvv[k+1] <= dvv[k];
      end
      if (ce) begin
        dv[k+1] <= nxt;
      end
    end
  end

  // Square both ratios.
  logic          vq;
  logic          tirq;
  logic [2*FB+1:0] rp_sq, rs_sq;
  logic [FB:0]   ratp, rats;

  assign ratp = dv[FB].one_p ? (FB+1)'(1) << FB : {1'b0, dv[FB].q_p};
  assign rats = dv[FB].one_s ? (FB+1)'(1) << FB : {1'b0, dv[FB].q_s};

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else if (ce) begin
      vq <= dvv[FB];
    end
    if (ce) begin
      tirq  <= dv[FB].tir;
      rp_sq <= (2*FB+2)'(ratp) * (2*FB+2)'(ratp);
      rs_sq <= (2*FB+2)'(rats) * (2*FB+2)'(rats);
    end
  end

  // Mean, rounding, saturation, and the output register.
  logic [2*FB+2:0] sum;
  logic [17:0]     refl_r;
  logic [16:0]     refl_sat;

  always_comb begin
    sum      = (2*FB+3)'(rp_sq) + (2*FB+3)'(rs_sq) + ((2*FB+3)'(1) << 24);
    refl_r   = 18'(sum >> 25);
    refl_sat = (refl_r > 18'(fdr_pkg::ONE_Q16)) ? fdr_pkg::ONE_Q16 : refl_r[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= vq;
    end
    if (ce) begin
      reflectance    <= tirq ? fdr_pkg::ONE_Q16 : refl_sat;
      total_internal <= tirq;
    end
  end

`ifndef SYNTH
  // Total internal reflection always reports exactly 1.0.
  a_tir_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && total_internal |-> reflectance == fdr_pkg::ONE_Q16)
    else $error("total internal reflection without full reflectance");

  // Reflectance never exceeds 1.0.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reflectance <= fdr_pkg::ONE_Q16)
    else $error("reflectance above 1.0");

  // A stalled result is neither dropped nor altered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reflectance)
      && $stable(total_internal))
    else $error("stalled result changed");

  // The input side is ready exactly when the pipeline can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready out of step with pipeline enable");
`endif

endmodule

FILE: test/tb_fresnel_dielectric_reflectance_top.sv
`timescale 1ns / 1ps
module tb_fresnel_dielectric_reflectance_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] cos_incident = '0;
  logic [15:0] index_incident = 16'h1000;
  logic [15:0] index_transmit = 16'h1000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] reflectance;
  logic        total_internal;

  fresnel_dielectric_reflectance_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cos_incident(cos_incident), .index_incident(index_incident),
    .index_transmit(index_transmit),
    .out_valid(out_valid), .out_ready(out_ready),
    .reflectance(reflectance), .total_internal(total_internal)
  );

  always #1 clk = ~clk;

  // Integer square root by the bitwise digit method.
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r, b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Magnitude of (a - b) / (a + b) in Q0.20, truncated; zero denominator is 1.0.
  function automatic logic [63:0] ratio_q20(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] num, den, rem, q;
    num = (a > b) ? a - b : b - a;
    den = a + b;
    q = 64'd0;
    if (den == 64'd0 || num >= den) return 64'd1 << 20;
    rem = num;
    for (int i = 0; i < 20; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  typedef struct {
    logic [16:0] refl;
    logic        tir;
  } refl_word_t;

  // Reflectance of one boundary crossing.
  function automatic refl_word_t fresnel_predict(input logic [15:0] craw,
                                                 input logic [15:0] ni,
                                                 input logic [15:0] nt);
    logic [63:0] ii, tt, c, s, n, q, rp, rs, sum, refl;
    refl_word_t w;
    ii = 64'(ni);
    tt = 64'(nt);
    if (craw != 16'd0 && !craw[15]) begin
      c = 64'(craw);
    end else begin
      ii = 64'(nt);
      tt = 64'(ni);
      c = (craw == 16'd0) ? 64'd0 : (64'h10000 - 64'(craw));
    end
    s = (64'd1 << 30) - c * c;
    if (ii * ii * s >= ((tt * tt) << 30)) begin
      w.refl = 17'h10000;
      w.tir = 1'b1;
      return w;
    end
    n = ((tt * tt) << 30) - ii * ii * s;
    q = root_floor(n);
    rp = ratio_q20(tt * tt * c, ii * q);
    rs = ratio_q20(ii * c, q);
    sum = rp * rp + rs * rs;
    refl = (sum + (64'd1 << 24)) >> 25;
    if (refl > 64'd65536) refl = 64'd65536;
    w.refl = refl[16:0];
    w.tir = 1'b0;
    return w;
  endfunction

  // Holds expected words in order and compares outgoing words against them.
  class refl_scoreboard;
    refl_word_t pending[$];
    int errors = 0;

    function void note_input(logic [15:0] c, logic [15:0] ni, logic [15:0] nt);
      pending.push_back(fresnel_predict(c, ni, nt));
    endfunction

    function void check_output(logic [16:0] refl, logic tir);
      refl_word_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected word: refl=%0d tir=%0b", refl, tir);
        return;
      end
      e = pending.pop_front();
      if (e.refl !== refl || e.tir !== tir) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected refl=%0d tir=%0b, got refl=%0d tir=%0b",
                   e.refl, e.tir, refl, tir);
      end
    endfunction
  endclass

  refl_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_rx = 1'b0;

  // Note accepted inputs and check outputs at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(cos_incident, index_incident, index_transmit);
      if (out_valid && out_ready) sb.check_output(reflectance, total_internal);
    end
  end

  // Receiver readiness with random stalls and one long hold-off.
  initial begin
    @(negedge clk);
    while (!rst === 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_rx) out_ready <= 1'b0;
      else out_ready <= quiet || ($urandom_range(99) >= 10);
    end
  end

  // Offer one word and wait for it to be taken.
  task automatic send_word(input logic [15:0] c, input logic [15:0] ni,
                           input logic [15:0] nt);
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cos_incident <= c;
    index_incident <= ni;
    index_transmit <= nt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [15:0] c, ni, nt;
    c = 16'($urandom);
    if ($urandom_range(3) == 0) begin
      ni = 16'($urandom_range(65535, 1));
      nt = 16'($urandom_range(65535, 1));
    end else begin
      // Physical indices around 1.0 to 3.0.
      ni = 16'($urandom_range(12288, 4096));
      nt = 16'($urandom_range(12288, 4096));
    end
    send_word(c, ni, nt);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: extremes of the cosine and indices, both directions, grazing.
    send_word(16'h7FFF, 16'h1000, 16'h1800);
    send_word(16'h8000, 16'h1000, 16'h1800);
    send_word(16'h0000, 16'h1000, 16'h1800);
    send_word(16'h0000, 16'h1800, 16'h1000);
    send_word(16'h0001, 16'h1000, 16'h1800);
    send_word(16'hFFFF, 16'h1000, 16'h1800);
    send_word(16'h4000, 16'h1800, 16'h1000);
    send_word(16'h1000, 16'h1800, 16'h1000);
    send_word(16'hC000, 16'h1000, 16'h1800);
    send_word(16'h4000, 16'h1000, 16'h1000);
    send_word(16'h7FFF, 16'h0001, 16'hFFFF);
    send_word(16'h7FFF, 16'hFFFF, 16'h0001);
    send_word(16'h8000, 16'hFFFF, 16'hFFFF);
    send_word(16'h0001, 16'hFFFF, 16'h0001);
    send_word(16'h5555, 16'hAAAA, 16'h5555);
    send_word(16'hAAAA, 16'h5555, 16'hAAAA);
    send_word(16'h7FFF, 16'h0001, 16'h0001);
    // Pause until every expected word has come back.
    wait_drained();
    for (int i = 0; i < 1450; i++) begin
      quiet = (i >= 400 && i < 700);
      if (i == 900) begin
        // Receiver holds off while the sender keeps offering.
        fork
          begin
            hold_rx = 1'b1;
            repeat (200) @(negedge clk);
            hold_rx = 1'b0;
          end
        join_none
      end
      if (i == 1200) wait_drained();
      send_random();
    end
    in_valid <= 1'b0;
    quiet = 1'b1;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (70) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
